>>> rtl/core/cds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_pkg
// shared types, sizes and constant tables of the clock display scanner
// ----------------------------------------------------------------------------
package cds_pkg;

  // matrix, display and pattern sizes
  localparam int MATRIX_ROWS    = 8;
  localparam int DIGIT_COUNT    = 4;
  localparam int PATTERN_LENGTH = 9;

  localparam int ROW_W   = $clog2(MATRIX_ROWS);
  localparam int DIGIT_W = $clog2(DIGIT_COUNT);
  localparam int PIDX_W  = (PATTERN_LENGTH > 1) ? $clog2(PATTERN_LENGTH) : 1;

  // fixed field widths
  localparam int PERIOD_W    = 16;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int SEC_W       = 6;
  localparam int SEG_W       = 7;
  localparam int COL_W       = 8;
  localparam int ROW_PIN_W   = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PAT_INDEX_W = 4;

  // reset values
  localparam logic [PERIOD_W-1:0] SECOND_PERIOD_RST = 16'd100;
  localparam logic [PERIOD_W-1:0] DIGIT_PERIOD_RST  = 16'd25;
  localparam logic [PERIOD_W-1:0] ROW_PERIOD_RST    = 16'd5;
  localparam logic [HOUR_W-1:0]   HOURS_RST         = 5'd15;
  localparam logic [MIN_W-1:0]    MINUTES_RST       = 6'd8;
  localparam logic [SEC_W-1:0]    SECONDS_RST       = 6'd50;
  localparam logic [PERIOD_W-1:0] COUNTDOWN_RST     = 16'd1;

  // carry limits of the clock fields, one bit wider to hold the increment
  localparam logic [SEC_W:0]  SEC_WRAP  = 7'd60;
  localparam logic [MIN_W:0]  MIN_WRAP  = 7'd60;
  localparam logic [HOUR_W:0] HOUR_WRAP = 6'd24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECOND_PERIOD  = 3'd0,
    REG_DIGIT_PERIOD   = 3'd1,
    REG_ROW_PERIOD     = 3'd2,
    REG_PRESET_HOURS   = 3'd3,
    REG_PRESET_MINUTES = 3'd4,
    REG_PRESET_SECONDS = 3'd5
  } reg_index_t;

  // item commands
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // digit scan positions
  typedef enum logic [DIGIT_W-1:0] {
    DIG_HOUR_TENS = 2'd0,
    DIG_HOUR_ONES = 2'd1,
    DIG_MIN_TENS  = 2'd2,
    DIG_MIN_ONES  = 2'd3
  } digit_pos_t;

  // one result transfer
  typedef struct packed {
    logic [DIGIT_COUNT-1:0] digit_enables;
    logic [SEG_W-1:0]       segment_levels;
    logic                   red_led;
    logic                   dot_led;
    logic [ROW_PIN_W-1:0]   row_enables;
    logic [COL_W-1:0]       column_data;
    logic [HOUR_W-1:0]      clock_hours;
    logic [MIN_W-1:0]       clock_minutes;
    logic [SEC_W-1:0]       clock_seconds;
  } res_t;

  // active-low segment pattern, bit 0 = a .. bit 6 = g
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] value);
    logic [SEG_W-1:0] code;
    unique case (value)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h10;
      default: code = 7'h7F;
    endcase
    return code;
  endfunction

  // startup picture for frame rows and pattern words, blank past the eighth
  function automatic logic [COL_W-1:0] init_word(input int idx);
    logic [COL_W-1:0] word;
    unique case (idx)
      0:       word = 8'hFF;
      1:       word = 8'h07;
      2:       word = 8'h03;
      3:       word = 8'h99;
      4:       word = 8'h99;
      5:       word = 8'h03;
      6:       word = 8'h07;
      default: word = 8'hFF;
    endcase
    return word;
  endfunction

endpackage

>>> rtl/core/cds_digit_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_digit_drive
// picks the hh:mm digit for the current scan position and encodes it
// ----------------------------------------------------------------------------
module cds_digit_drive
  import cds_pkg::*;
(
  input  logic [HOUR_W-1:0]      hours,
  input  logic [MIN_W-1:0]       minutes,
  input  logic [DIGIT_W-1:0]     scan_digit,
  output logic [DIGIT_COUNT-1:0] digit_enables,
  output logic [SEG_W-1:0]       segment_levels
);

  // tens of a value below 64, compare chain
  function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] v);
    logic [3:0] t;
    priority if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50)     t = 4'd5;
    else if (v >= 6'd40)     t = 4'd4;
    else if (v >= 6'd30)     t = 4'd3;
    else if (v >= 6'd20)     t = 4'd2;
    else if (v >= 6'd10)     t = 4'd1;
    else                     t = 4'd0;
    return t;
  endfunction

  logic [MIN_W-1:0] hours_wide;
  logic [3:0]       hour_tens;
  logic [3:0]       min_tens;
  logic [MIN_W-1:0] hour_ones;
  logic [MIN_W-1:0] min_ones;
  logic [3:0]       shown;

  assign hours_wide = MIN_W'(hours);
  assign hour_tens  = tens_of(hours_wide);
  assign min_tens   = tens_of(minutes);
  assign hour_ones  = hours_wide - MIN_W'(hour_tens) * 6'd10;
  assign min_ones   = minutes - MIN_W'(min_tens) * 6'd10;

  always_comb begin
    unique case (digit_pos_t'(scan_digit))
      DIG_HOUR_TENS: shown = hour_tens;
      DIG_HOUR_ONES: shown = hour_ones[3:0];
      DIG_MIN_TENS:  shown = min_tens;
      DIG_MIN_ONES:  shown = min_ones[3:0];
      default:       shown = 4'd0;
    endcase
  end

  assign digit_enables  = ~(DIGIT_COUNT'(1) << scan_digit);
  assign segment_levels = seg_code(shown);

endmodule

>>> rtl/core/cds_out_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_out_buffer
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module cds_out_buffer
  import cds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // output register frees up: oldest entry moves in first
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> rtl/core/clock_display_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_display_scanner_core
// 24-hour clock on four scanned seven-segment digits plus a scrolling matrix
// ----------------------------------------------------------------------------
// Each accepted item is either a timer tick (cmd 0) or a pattern word write
// (cmd 1), and each gives exactly one result transfer carrying the pin levels
// and the clock after that item. The whole update is done in the cycle of
// acceptance and the result is registered in the output buffer; a new item is
// taken every cycle while in_stall is low. Results pass through a
// two-entry buffer (output register and skid register), so in_stall goes high
// only when both entries hold untaken results. On a tick three dividers run:
// the digit divider steps the digit scan (showing the time from before this
// tick's increment) and toggles the red and dot LEDs, the second divider
// advances hh:mm:ss, and the row divider steps the matrix row scan, shifting
// the frame up and appending the next pattern word each time the scan wraps.
// Configuration writes are always ready; a new period is picked up at the
// next reload of its divider, and writing a preset also loads that clock
// field at once. A period of zero stops its divider.
// ----------------------------------------------------------------------------
module clock_display_scanner_core
  import cds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [PAT_INDEX_W-1:0] pattern_index,
  input  logic [COL_W-1:0]       pattern_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIGIT_COUNT-1:0] digit_enables,
  output logic [SEG_W-1:0]       segment_levels,
  output logic                   red_led,
  output logic                   dot_led,
  output logic [ROW_PIN_W-1:0]   row_enables,
  output logic [COL_W-1:0]       column_data,
  output logic [HOUR_W-1:0]      clock_hours,
  output logic [MIN_W-1:0]       clock_minutes,
  output logic [SEC_W-1:0]       clock_seconds,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // countdown step: fires at one and reloads the period there, counts down above one, holds at zero
  function automatic logic [PERIOD_W-1:0] count_next(
    input logic [PERIOD_W-1:0] cd,
    input logic [PERIOD_W-1:0] period
  );
    logic [PERIOD_W-1:0] nxt;
    if (cd == PERIOD_W'(1))      nxt = period;
    else if (cd != '0)           nxt = cd - PERIOD_W'(1);
    else                         nxt = cd;
    return nxt;
  endfunction

  // divider periods
  logic [PERIOD_W-1:0] second_period, second_period_next;
  logic [PERIOD_W-1:0] digit_period, digit_period_next;
  logic [PERIOD_W-1:0] row_period, row_period_next;

  // clock
  logic [HOUR_W-1:0] hours, hours_next;
  logic [MIN_W-1:0]  minutes, minutes_next;
  logic [SEC_W-1:0]  seconds, seconds_next;

  // dividers and scan positions
  logic [PERIOD_W-1:0] second_countdown, second_countdown_next;
  logic [PERIOD_W-1:0] digit_countdown, digit_countdown_next;
  logic [PERIOD_W-1:0] row_countdown, row_countdown_next;
  logic [DIGIT_W-1:0]  scan_digit, scan_digit_next;
  logic [ROW_W-1:0]    scan_row, scan_row_next;
  logic [PIDX_W-1:0]   pattern_position, pattern_position_next;

  // matrix picture and pattern words
  logic [COL_W-1:0] frame_rows [MATRIX_ROWS];
  logic [COL_W-1:0] frame_next [MATRIX_ROWS];
  logic [COL_W-1:0] pattern_table [PATTERN_LENGTH];

  // latched pin levels
  logic [DIGIT_COUNT-1:0] digit_pins, digit_pins_next;
  logic [SEG_W-1:0]       seg_pins, seg_pins_next;
  logic                   red_pin, red_pin_next;
  logic                   dot_pin, dot_pin_next;
  logic [ROW_PIN_W-1:0]   row_pins, row_pins_next;
  logic [COL_W-1:0]       col_pins, col_pins_next;

  // item decode
  logic push;
  logic tick;
  logic pat_write;
  logic cfg_write;
  logic digit_fire;
  logic second_fire;
  logic row_fire;
  logic row_wrap;

  // digit drive for the current scan position
  logic [DIGIT_COUNT-1:0] step_enables;
  logic [SEG_W-1:0]       step_segments;

  // clock increment with carries
  logic [SEC_W:0]  sec_inc;
  logic [MIN_W:0]  min_inc;
  logic [HOUR_W:0] hour_inc;
  logic [HOUR_W-1:0] hours_step;
  logic [MIN_W-1:0]  minutes_step;
  logic [SEC_W-1:0]  seconds_step;

  res_t push_data;
  res_t out_data;

  assign push      = in_valid && !in_stall;
  assign tick      = push && (cmd_t'(cmd) == CMD_TICK);
  assign pat_write = push && (cmd_t'(cmd) == CMD_WRITE);
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign digit_fire  = tick && (digit_countdown == PERIOD_W'(1));
  assign second_fire = tick && (second_countdown == PERIOD_W'(1));
  assign row_fire    = tick && (row_countdown == PERIOD_W'(1));

  cds_digit_drive u_digit (
    .hours          (hours),
    .minutes        (minutes),
    .scan_digit     (scan_digit),
    .digit_enables  (step_enables),
    .segment_levels (step_segments)
  );

  // seconds carry into minutes, minutes into hours; out-of-range fields carry too
  always_comb begin
    sec_inc = {1'b0, seconds} + 7'd1;
    if (sec_inc >= SEC_WRAP) begin
      seconds_step = '0;
      min_inc      = {1'b0, minutes} + 7'd1;
    end else begin
      seconds_step = sec_inc[SEC_W-1:0];
      min_inc      = {1'b0, minutes};
    end
    if (min_inc >= MIN_WRAP) begin
      minutes_step = '0;
      hour_inc     = {1'b0, hours} + 6'd1;
    end else begin
      minutes_step = min_inc[MIN_W-1:0];
      hour_inc     = {1'b0, hours};
    end
    if (hour_inc >= HOUR_WRAP) begin
      hours_step = '0;
    end else begin
      hours_step = hour_inc[HOUR_W-1:0];
    end
  end

  // row scan: wrap past the last row shifts the frame and appends a word
  always_comb begin
    row_wrap              = 1'b0;
    scan_row_next         = scan_row;
    pattern_position_next = pattern_position;
    frame_next            = frame_rows;
    if (row_fire) begin
      if (int'(scan_row) + 1 >= MATRIX_ROWS) begin
        row_wrap      = 1'b1;
        scan_row_next = '0;
      end else begin
        scan_row_next = scan_row + ROW_W'(1);
      end
    end
    if (row_wrap) begin
      if (int'(pattern_position) + 1 >= PATTERN_LENGTH) begin
        pattern_position_next = '0;
      end else begin
        pattern_position_next = pattern_position + PIDX_W'(1);
      end
      for (int i = 0; i < MATRIX_ROWS - 1; i++) begin
        frame_next[i] = frame_rows[i + 1];
      end
      frame_next[MATRIX_ROWS-1] = pattern_table[pattern_position_next];
    end
  end

  // next values of the registers; the user must see that config only arrives while idle, the block does not enforce it
  always_comb begin
    second_period_next = second_period;
    digit_period_next  = digit_period;
    row_period_next    = row_period;
    hours_next         = second_fire ? hours_step : hours;
    minutes_next       = second_fire ? minutes_step : minutes;
    seconds_next       = second_fire ? seconds_step : seconds;

    if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_SECOND_PERIOD:  second_period_next = cfg_data;
        REG_DIGIT_PERIOD:   digit_period_next  = cfg_data;
        REG_ROW_PERIOD:     row_period_next    = cfg_data;
        REG_PRESET_HOURS:   hours_next         = cfg_data[HOUR_W-1:0];
        REG_PRESET_MINUTES: minutes_next       = cfg_data[MIN_W-1:0];
        REG_PRESET_SECONDS: seconds_next       = cfg_data[SEC_W-1:0];
        default: ;
      endcase
    end

    second_countdown_next = tick ? count_next(second_countdown, second_period)
                                 : second_countdown;
    digit_countdown_next  = tick ? count_next(digit_countdown, digit_period)
                                 : digit_countdown;
    row_countdown_next    = tick ? count_next(row_countdown, row_period)
                                 : row_countdown;

    scan_digit_next = digit_fire ? scan_digit + DIGIT_W'(1) : scan_digit;
    digit_pins_next = digit_fire ? step_enables : digit_pins;
    seg_pins_next   = digit_fire ? step_segments : seg_pins;
    red_pin_next    = digit_fire ? !red_pin : red_pin;
    dot_pin_next    = digit_fire ? !dot_pin : dot_pin;

    // rows past the eighth shift out of the pin byte and read all high
    row_pins_next = row_fire ? ~(ROW_PIN_W'(1) << scan_row_next) : row_pins;
    col_pins_next = row_fire ? frame_next[scan_row_next] : col_pins;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_period    <= SECOND_PERIOD_RST;
      digit_period     <= DIGIT_PERIOD_RST;
      row_period       <= ROW_PERIOD_RST;
      hours            <= HOURS_RST;
      minutes          <= MINUTES_RST;
      seconds          <= SECONDS_RST;
      second_countdown <= COUNTDOWN_RST;
      digit_countdown  <= COUNTDOWN_RST;
      row_countdown    <= COUNTDOWN_RST;
      scan_digit       <= '0;
      scan_row         <= '0;
      pattern_position <= '0;
      digit_pins       <= '0;
      seg_pins         <= '0;
      red_pin          <= 1'b0;
      dot_pin          <= 1'b0;
      row_pins         <= '0;
      col_pins         <= '0;
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        frame_rows[i] <= init_word(i);
      end
      for (int i = 0; i < PATTERN_LENGTH; i++) begin
        pattern_table[i] <= init_word(i);
      end
    end else begin
      second_period    <= second_period_next;
      digit_period     <= digit_period_next;
      row_period       <= row_period_next;
      hours            <= hours_next;
      minutes          <= minutes_next;
      seconds          <= seconds_next;
      second_countdown <= second_countdown_next;
      digit_countdown  <= digit_countdown_next;
      row_countdown    <= row_countdown_next;
      scan_digit       <= scan_digit_next;
      scan_row         <= scan_row_next;
      pattern_position <= pattern_position_next;
      digit_pins       <= digit_pins_next;
      seg_pins         <= seg_pins_next;
      red_pin          <= red_pin_next;
      dot_pin          <= dot_pin_next;
      row_pins         <= row_pins_next;
      col_pins         <= col_pins_next;
      frame_rows       <= frame_next;
      // pattern writes beyond the table are dropped
      if (pat_write && (int'(pattern_index) < PATTERN_LENGTH)) begin
        pattern_table[pattern_index[PIDX_W-1:0]] <= pattern_data;
      end
    end
  end

  // result of this item: pins and clock after the update
  always_comb begin
    push_data.digit_enables  = digit_pins_next;
    push_data.segment_levels = seg_pins_next;
    push_data.red_led        = red_pin_next;
    push_data.dot_led        = dot_pin_next;
    push_data.row_enables    = row_pins_next;
    push_data.column_data    = col_pins_next;
    push_data.clock_hours    = hours_next;
    push_data.clock_minutes  = minutes_next;
    push_data.clock_seconds  = seconds_next;
  end

  cds_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign digit_enables  = out_data.digit_enables;
  assign segment_levels = out_data.segment_levels;
  assign red_led        = out_data.red_led;
  assign dot_led        = out_data.dot_led;
  assign row_enables    = out_data.row_enables;
  assign column_data    = out_data.column_data;
  assign clock_hours    = out_data.clock_hours;
  assign clock_minutes  = out_data.clock_minutes;
  assign clock_seconds  = out_data.clock_seconds;

`ifndef SYNTHESIS
  // skid entry only fills behind a held output register
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("skid entry full while output register empty");

  // an accepted item into an empty buffer shows up next cycle
  assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> out_valid)
    else $error("result lost after transfer into empty buffer");

  // an accepted item behind a stalled result fills the skid entry
  assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && out_stall) |=> in_stall)
    else $error("result behind stalled output not held in skid entry");

  // dividers only move on ticks
  assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(digit_countdown) && $stable(row_countdown))
    else $error("divider moved without a tick");
`endif

endmodule
